// ===== sv/atm_pkg.sv =====
package atm_pkg;

    localparam int FRAC_BITS_DEF        = 16;
    localparam int GAMMA_INDEX_BITS_DEF = 12;
    localparam int GAMMA_INDEX_MAX      = 16;
    localparam int IN_W                 = 32;
    localparam int OUT_W                = 8;
    localparam int GAIN_W               = 24;
    localparam int GAIN_FRAC            = 16;
    localparam int ADDR_W               = 3;
    localparam int DATA_W               = 32;
    localparam int LEVELS               = 256;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    // register index is paddr[ADDR_W-1]
    localparam logic REG_EXPOSURE_GAIN = 1'b0;

    typedef struct packed {
        logic                       we;
        logic [GAMMA_INDEX_MAX-1:0] addr;
        logic [OUT_W-1:0]           data;
        logic                       done;
    } gamma_wr_t;

    // smallest table index whose byte exceeds k: 510^11 * i^5 >= (2k+1)^11 * 2^(5g)
    function automatic logic [GAMMA_INDEX_MAX:0] gamma_threshold(input int k, input int g);
        logic [255:0] lim;
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] p;
        int lo;
        int hi;
        int mid;
        int n;
        lim = 256'd1;
        rhs = 256'd1;
        for (n = 0; n < 11; n++) begin
            lim = lim * 256'd510;
            rhs = rhs * 256'(2 * k + 1);
        end
        for (n = 0; n < 5; n++) begin
            rhs = rhs << g;
        end
        lo = 0;
        hi = 1 << g;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            p = 256'd1;
            for (n = 0; n < 5; n++) begin
                p = p * 256'(mid);
            end
            lhs = lim * p;
            if (lhs >= rhs) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return (GAMMA_INDEX_MAX + 1)'(lo);
    endfunction

endpackage

// ===== sv/atm_ram.sv =====
module atm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/atm_gamma_fill.sv =====
module atm_gamma_fill #(
    parameter int GAMMA_INDEX_BITS = atm_pkg::GAMMA_INDEX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    output atm_pkg::gamma_wr_t  wr
);
    import atm_pkg::*;

    localparam int G = GAMMA_INDEX_BITS;

    logic [G:0]             thr [LEVELS];
    logic [OUT_W-1:0]       k_reg, k_next;
    logic [G-1:0]           i_reg, i_next;
    logic                   done_reg, done_next;
    logic                   bump;
    logic                   we;

    for (genvar k = 0; k < LEVELS; k++) begin : g_thr
        if (k == LEVELS - 1) begin : g_top
            assign thr[k] = '1;
        end else begin : g_val
            localparam logic [GAMMA_INDEX_MAX:0] T = gamma_threshold(k, G);
            assign thr[k] = T[G:0];
        end
    end

    assign bump = (k_reg != OUT_W'(LEVELS - 1)) && ({1'b0, i_reg} >= thr[k_reg]);

    always_comb begin
        k_next    = k_reg;
        i_next    = i_reg;
        done_next = done_reg;
        we        = 1'b0;
        if (!done_reg) begin
            if (bump) begin
                k_next = k_reg + 1'b1;
            end else begin
                we     = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == '1) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= '0;
            i_reg    <= '0;
            done_reg <= 1'b0;
        end else begin
            k_reg    <= k_next;
            i_reg    <= i_next;
            done_reg <= done_next;
        end
    end

    assign wr.we   = we;
    assign wr.addr = GAMMA_INDEX_MAX'(i_reg);
    assign wr.data = k_reg;
    assign wr.done = done_reg;

endmodule

// ===== sv/atm_channel.sv =====
module atm_channel #(
    parameter int FRAC_BITS        = atm_pkg::FRAC_BITS_DEF,
    parameter int GAMMA_INDEX_BITS = atm_pkg::GAMMA_INDEX_BITS_DEF
) (
    input  logic                             aclk,
    input  logic [FRAC_BITS+5:0]             stage_en,
    input  logic signed [atm_pkg::IN_W-1:0]  linear,
    input  logic [atm_pkg::GAIN_W-1:0]       gain,
    output logic [GAMMA_INDEX_BITS-1:0]      gamma_idx
);
    import atm_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int G  = GAMMA_INDEX_BITS;
    localparam int VW = IN_W - 1;
    localparam int PW = VW + GAIN_W;
    localparam int EW = PW - GAIN_FRAC;
    localparam int XW = F + 4;
    localparam int CW = F + 11;
    localparam int DW = 2 * F + 14;
    localparam int DS = 5;   // first divider stage

    localparam logic [XW-1:0] X_SAT   = XW'(8) << F;
    localparam logic [CW-1:0] A_OFFS  = CW'(3) << F;
    localparam logic [CW-1:0] B_OFFS  = CW'(59) << F;
    localparam logic [DW-1:0] D_OFFS  = DW'(14) << (2 * F);

    logic [VW-1:0]  v_reg;
    logic [PW-1:0]  p_reg;
    logic [XW-1:0]  x_reg, x_next;
    logic [XW-1:0]  x3_reg;
    logic [CW-1:0]  a_reg, b_reg;
    logic [DW-1:0]  num_reg, den_reg;
    logic [DW-1:0]  r_reg   [F];
    logic [DW-1:0]  d_reg   [F];
    logic [F-1:0]   q_reg   [F+1];
    logic           sat_reg [F+1];
    logic [EW-1:0]  x_raw;
    logic [G-1:0]   idx_q;

    assign x_raw  = p_reg[PW-1:GAIN_FRAC];
    assign x_next = (x_raw > EW'(X_SAT)) ? X_SAT : x_raw[XW-1:0];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            v_reg <= linear[IN_W-1] ? '0 : linear[VW-1:0];
        end
        if (stage_en[1]) begin
            p_reg <= PW'(v_reg) * PW'(gain);
        end
        if (stage_en[2]) begin
            x_reg <= x_next;
        end
        if (stage_en[3]) begin
            x3_reg <= x_reg;
            a_reg  <= CW'(x_reg) * CW'(251) + A_OFFS;
            b_reg  <= CW'(x_reg) * CW'(243) + B_OFFS;
        end
        if (stage_en[4]) begin
            num_reg <= DW'(x3_reg) * DW'(a_reg);
            den_reg <= DW'(x3_reg) * DW'(b_reg) + D_OFFS;
        end
        if (stage_en[DS]) begin
            r_reg[0]   <= num_reg;
            d_reg[0]   <= den_reg;
            q_reg[0]   <= '0;
            sat_reg[0] <= num_reg >= den_reg;
        end
    end

    for (genvar j = 1; j <= F; j++) begin : g_div
        logic [DW:0]   r2;
        logic          hit;
        logic [DW:0]   diff;

        assign r2   = {r_reg[j-1], 1'b0};
        assign hit  = r2 >= {1'b0, d_reg[j-1]};
        assign diff = r2 - {1'b0, d_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (stage_en[DS+j]) begin
                q_reg[j]   <= {q_reg[j-1][F-2:0], hit};
                sat_reg[j] <= sat_reg[j-1];
            end
        end

        if (j < F) begin : g_rem
            always_ff @(posedge aclk) begin
                if (stage_en[DS+j]) begin
                    r_reg[j] <= hit ? diff[DW-1:0] : r2[DW-1:0];
                    d_reg[j] <= d_reg[j-1];
                end
            end
        end
    end

    if (F >= G) begin : g_idx_cut
        assign idx_q = q_reg[F][F-1 -: G];
    end else begin : g_idx_pad
        assign idx_q = {q_reg[F], (G - F)'(0)};
    end

    assign gamma_idx = sat_reg[F] ? '1 : idx_q;

endmodule

// ===== sv/aces_tone_map_srgb8.sv =====
// ACES filmic tone mapper with gamma 1/2.2 encoding: one RGB pixel in signed Q15.16 per
// cycle unless the output stalls or the table is being built, three display bytes out. The
// quotient of the curve takes one restoring-divider stage per fraction bit, and the last
// stage is the registered read of the gamma table. After reset the gamma table is built
// in RAM with s_ready held low; register writes are taken meanwhile. exposure_gain sits
// at byte address 0 and should only be changed while the pipeline is empty.
module aces_tone_map_srgb8 #(
    parameter int FRAC_BITS        = atm_pkg::FRAC_BITS_DEF,
    parameter int GAMMA_INDEX_BITS = atm_pkg::GAMMA_INDEX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [atm_pkg::ADDR_W-1:0]        paddr,
    input  logic [atm_pkg::DATA_W-1:0]        pwdata,
    output logic [atm_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [atm_pkg::IN_W-1:0]   s_linear_red,
    input  logic signed [atm_pkg::IN_W-1:0]   s_linear_green,
    input  logic signed [atm_pkg::IN_W-1:0]   s_linear_blue,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [atm_pkg::OUT_W-1:0]         m_display_red,
    output logic [atm_pkg::OUT_W-1:0]         m_display_green,
    output logic [atm_pkg::OUT_W-1:0]         m_display_blue
);
    import atm_pkg::*;

    localparam int G     = GAMMA_INDEX_BITS;
    localparam int NS    = FRAC_BITS + 7;
    localparam int DEPTH = 1 << G;

    logic [GAIN_W-1:0]  gain_reg;
    logic [NS-1:0]      vld_reg;
    logic [NS:0]        stage_en;
    gamma_wr_t          wr;
    logic [G-1:0]       idx_r, idx_g, idx_b;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1] == REG_EXPOSURE_GAIN) begin
            gain_reg <= pwdata[GAIN_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1])
            REG_EXPOSURE_GAIN: prdata = DATA_W'(gain_reg);
            default:           prdata = '0;
        endcase
    end

    // a stage loads when empty or when its word moves on
    always_comb begin
        stage_en[NS] = m_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign s_ready = wr.done && stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                vld_reg[0] <= s_valid && wr.done;
            end
            for (int i = 1; i < NS; i++) begin
                if (stage_en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    atm_gamma_fill #(.GAMMA_INDEX_BITS(G)) u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr)
    );

    atm_channel #(.FRAC_BITS(FRAC_BITS), .GAMMA_INDEX_BITS(G)) u_ch_red (
        .aclk      (aclk),
        .stage_en  (stage_en[NS-2:0]),
        .linear    (s_linear_red),
        .gain      (gain_reg),
        .gamma_idx (idx_r)
    );

    atm_channel #(.FRAC_BITS(FRAC_BITS), .GAMMA_INDEX_BITS(G)) u_ch_green (
        .aclk      (aclk),
        .stage_en  (stage_en[NS-2:0]),
        .linear    (s_linear_green),
        .gain      (gain_reg),
        .gamma_idx (idx_g)
    );

    atm_channel #(.FRAC_BITS(FRAC_BITS), .GAMMA_INDEX_BITS(G)) u_ch_blue (
        .aclk      (aclk),
        .stage_en  (stage_en[NS-2:0]),
        .linear    (s_linear_blue),
        .gain      (gain_reg),
        .gamma_idx (idx_b)
    );

    atm_ram #(.WIDTH(OUT_W), .DEPTH(DEPTH)) u_lut_red (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.addr[G-1:0]),
        .wdata (wr.data),
        .re    (stage_en[NS-1]),
        .raddr (idx_r),
        .rdata (m_display_red)
    );

    atm_ram #(.WIDTH(OUT_W), .DEPTH(DEPTH)) u_lut_green (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.addr[G-1:0]),
        .wdata (wr.data),
        .re    (stage_en[NS-1]),
        .raddr (idx_g),
        .rdata (m_display_green)
    );

    atm_ram #(.WIDTH(OUT_W), .DEPTH(DEPTH)) u_lut_blue (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.addr[G-1:0]),
        .wdata (wr.data),
        .re    (stage_en[NS-1]),
        .raddr (idx_b),
        .rdata (m_display_blue)
    );

    assign m_valid = vld_reg[NS-1];

endmodule

// ===== sv/atm_checker.sv =====
module atm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              psel,
    input logic                              pwrite,
    input logic [atm_pkg::ADDR_W-1:0]        paddr,
    input logic [atm_pkg::DATA_W-1:0]        prdata,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [atm_pkg::OUT_W-1:0]         m_display_red,
    input logic [atm_pkg::OUT_W-1:0]         m_display_green,
    input logic [atm_pkg::OUT_W-1:0]         m_display_blue
);
    import atm_pkg::*;

    // table build blocks input straight after reset
    a_fill_after_reset: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("s_ready high during gamma table build");

    a_empty_after_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word without input");

    a_gain_reset: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn && psel && !pwrite && paddr[ADDR_W-1] == REG_EXPOSURE_GAIN
        |-> prdata == DATA_W'(GAIN_RESET))
        else $error("exposure_gain reset value wrong");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_display_red)
        && $stable(m_display_green) && $stable(m_display_blue))
        else $error("stalled output word changed");

endmodule

bind aces_tone_map_srgb8 atm_checker u_atm_checker (.*);
